// ===== rtl/core/sib_pkg.sv =====
`timescale 1ns / 1ps
package sib_pkg;

    // Buffer geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEVELS   = $clog2(CAPACITY);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Sort modes; the unused code falls back to ascending depth
    localparam logic [1:0] MODE_ASC_DEPTH  = 2'd0;
    localparam logic [1:0] MODE_DESC_DEPTH = 2'd1;
    localparam logic [1:0] MODE_DESC_TEX   = 2'd2;

    // Register index of sort_mode
    localparam logic REG_SORT_MODE = 1'b0;

    typedef struct packed {
        logic signed [31:0] depth;
        logic [15:0]        texture;
        logic [15:0]        tag;
    } t_entry;

    // Per-cell update control
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== rtl/core/sib_cell.sv =====
`timescale 1ns / 1ps
module sib_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_mode,
    input  sib_pkg::t_entry    i_item,
    input  logic               i_cmp_en,
    input  logic               i_live,
    input  sib_pkg::t_cell_ctl i_ctl,
    input  sib_pkg::t_entry    i_prev,
    output sib_pkg::t_entry    o_entry,
    output logic               o_ahead
);

    sib_pkg::t_entry r_entry;
    logic            r_ahead;
    logic            n_ahead;

    // Decide whether the held entry goes after the new item
    always_comb begin
        unique case (i_mode)
            sib_pkg::MODE_DESC_DEPTH: n_ahead = r_entry.depth < i_item.depth;
            sib_pkg::MODE_DESC_TEX:   n_ahead = r_entry.texture < i_item.texture;
            default:                  n_ahead = r_entry.depth > i_item.depth;
        endcase
        n_ahead = n_ahead & i_live;
    end

    // Hold the compare result for the update cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ahead <= 1'b0;
        end else if (i_cmp_en) begin
            r_ahead <= n_ahead;
        end
    end

    // Take the new item, or the neighbor's entry on a shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_item;
        end else if (i_ctl.shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_ahead = r_ahead;

endmodule

// ===== rtl/core/sib_prefix.sv =====
`timescale 1ns / 1ps
module sib_prefix (
    input  logic [sib_pkg::CAPACITY-1:0] i_ahead,
    output logic [sib_pkg::CAPACITY-1:0] o_before,
    output logic [sib_pkg::CAPACITY-1:0] o_first,
    output logic                         o_any,
    output logic [sib_pkg::IDX_W-1:0]    o_first_idx
);

    logic [sib_pkg::CAPACITY-1:0] acc;

    // Log-depth inclusive prefix OR over the cell flags
    always_comb begin
        acc = i_ahead;
        for (int lvl = 0; lvl < sib_pkg::LEVELS; lvl++) begin
            acc = acc | (acc << (1 << lvl));
        end
    end

    assign o_before = acc << 1;
    assign o_first  = i_ahead & ~o_before;
    assign o_any    = acc[sib_pkg::CAPACITY-1];

    // Encode the one-hot first flag
    always_comb begin
        o_first_idx = '0;
        for (int i = 0; i < sib_pkg::CAPACITY; i++) begin
            if (o_first[i]) begin
                o_first_idx = o_first_idx | sib_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/core/sorted_insertion_buffer.sv =====
`timescale 1ns / 1ps
// Sorted insertion buffer: a bounded list of render items (depth, texture, tag)
// kept in order by a row of cells, one cell per list position.
// Input channel: i_in_valid / o_in_stall with opcode and item fields; a transfer
// happens when valid is high and stall is low. Output channel: o_out_valid /
// i_out_stall, one result per input transfer, with status, position, read data
// and the entry count after the operation.
// The result passes two states after its input transfer: in S_CMP every cell compares
// its entry with the new item; in S_EXEC the prefix search runs, all later cells shift
// and the result is registered. The next transfer is taken once the block is idle and
// the result register is free or being drained, so no new item is taken before the
// last one is through the update. While the receiver stalls, the result holds and the
// input side stalls as well. sort_mode is written through the APB port at byte
// address 0; the user must do so only while the block is idle, and the block does not
// enforce it. Reset (synchronous, active low) empties the list and sets the sort mode
// to ascending depth; no clearing pass runs over the cells.
module sorted_insertion_buffer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic signed [31:0]  i_depth_key,
    input  logic [15:0]         i_texture_key,
    input  logic [15:0]         i_item_tag,
    input  logic [5:0]          i_read_index,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [6:0]          o_position,
    output logic signed [31:0]  o_out_depth,
    output logic [15:0]         o_out_texture,
    output logic [15:0]         o_out_tag,
    output logic [6:0]          o_entry_count
);

    localparam int N = sib_pkg::CAPACITY;
    localparam int CW = sib_pkg::CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [1:0]                 r_sort_mode;
    logic [CW-1:0]              r_count;
    logic [1:0]                 r_op;
    logic [sib_pkg::IDX_W-1:0]  r_ri;
    sib_pkg::t_entry            r_item;

    logic                       r_out_valid;
    logic [1:0]                 r_status;
    logic [1:0]                 n_status;
    logic [6:0]                 r_position;
    logic [6:0]                 n_position;
    sib_pkg::t_entry            r_out;
    sib_pkg::t_entry            n_out;
    logic [6:0]                 r_entry_count;
    logic [6:0]                 n_entry_count;

    logic                       in_xfer;
    logic                       cfg_wr;
    logic                       full;
    logic                       do_insert;
    logic [N-1:0]               ahead;
    logic [N-1:0]               shift_vec;
    logic [N-1:0]               first;
    logic [N-1:0]               load_vec;
    logic                       any;
    logic [sib_pkg::IDX_W-1:0]  first_idx;
    logic [CW-1:0]              ins_pos;
    sib_pkg::t_entry            entries [N];
    sib_pkg::t_entry            sel_entry;

    // Configuration port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign o_prdata = (i_paddr[2] == sib_pkg::REG_SORT_MODE) ? {30'd0, r_sort_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_mode <= sib_pkg::MODE_ASC_DEPTH;
        end else if (cfg_wr && i_paddr[2] == sib_pkg::REG_SORT_MODE) begin
            r_sort_mode <= i_pwdata[1:0];
        end
    end

    // Input handshake: take a transfer when idle and the result slot frees up
    assign o_in_stall = (r_state != S_IDLE) | (r_out_valid & i_out_stall);
    assign in_xfer    = i_in_valid & ~o_in_stall;

    // Sequence one operation: compare, then update
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = in_xfer ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op          <= i_opcode;
            r_ri          <= i_read_index;
            r_item.depth   <= i_depth_key;
            r_item.texture <= i_texture_key;
            r_item.tag     <= i_item_tag;
        end
    end

    assign full      = (r_count == CW'(N));
    assign do_insert = (r_state == S_EXEC) && (r_op == sib_pkg::OP_INSERT) && !full;

    // Row of cells
    for (genvar i = 0; i < N; i++) begin : g_cell
        sib_pkg::t_cell_ctl ctl;
        sib_pkg::t_entry    prev;

        assign load_vec[i] = first[i] | (~any & (CW'(i) == r_count));
        assign ctl.load    = do_insert & load_vec[i];
        assign ctl.shift   = do_insert & shift_vec[i];

        if (i == 0) begin : g_head
            assign prev = r_item;
        end else begin : g_body
            assign prev = entries[i-1];
        end

        sib_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_mode   (r_sort_mode),
            .i_item   (r_item),
            .i_cmp_en (r_state == S_CMP),
            .i_live   (CW'(i) < r_count),
            .i_ctl    (ctl),
            .i_prev   (prev),
            .o_entry  (entries[i]),
            .o_ahead  (ahead[i])
        );
    end

    // Find the first cell that the new item goes ahead of
    sib_prefix u_prefix (
        .i_ahead     (ahead),
        .o_before    (shift_vec),
        .o_first     (first),
        .o_any       (any),
        .o_first_idx (first_idx)
    );

    assign ins_pos   = any ? CW'(first_idx) : r_count;
    assign sel_entry = entries[r_ri];

    // Update count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EXEC) begin
                if (do_insert) begin
                    r_count <= r_count + CW'(1);
                end else if (r_op == sib_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end
            end
        end
    end

    // Form the result of the operation
    always_comb begin
        n_status      = sib_pkg::ST_OK;
        n_position    = '0;
        n_out         = '0;
        n_entry_count = 7'(r_count);
        unique case (r_op)
            sib_pkg::OP_INSERT: begin
                if (full) begin
                    n_status = sib_pkg::ST_FULL;
                end else begin
                    n_position    = 7'(ins_pos);
                    n_entry_count = 7'(r_count + CW'(1));
                end
            end
            sib_pkg::OP_READ: begin
                if (CW'(r_ri) >= r_count) begin
                    n_status = sib_pkg::ST_RANGE;
                end else begin
                    n_out = sel_entry;
                end
            end
            sib_pkg::OP_CLEAR: begin
                n_entry_count = '0;
            end
            default: begin
                n_status = sib_pkg::ST_OK;
            end
        endcase
    end

    // Register the result in the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_status      <= n_status;
            r_position    <= n_position;
            r_out         <= n_out;
            r_entry_count <= n_entry_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_out_depth   = r_out.depth;
    assign o_out_texture = r_out.texture;
    assign o_out_tag     = r_out.tag;
    assign o_entry_count = r_entry_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("entry count above capacity");

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(load_vec))
        else $error("more than one cell takes the new item");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result raised outside the update cycle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sib_pkg::ST_FULL) |-> (o_entry_count == 7'(N)))
        else $error("full status with buffer not full");
`endif

endmodule

// ===== tb/sv/sorted_list_checker.sv =====
`timescale 1ns / 1ps
module sorted_list_checker
    import sib_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    // input channel
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_depth_key,
    input  logic [15:0]        i_texture_key,
    input  logic [15:0]        i_item_tag,
    input  logic [5:0]         i_read_index,
    // output channel
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic [6:0]         i_position,
    input  logic signed [31:0] i_out_depth,
    input  logic [15:0]        i_out_texture,
    input  logic [15:0]        i_out_tag,
    input  logic [6:0]         i_entry_count,
    // summary for the top
    output int                 o_fail_count,
    output int                 o_replies_outstanding
);

    localparam logic [2:0] SORT_MODE_ADDR = {REG_SORT_MODE, 2'b00};

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         position;
        logic signed [31:0] depth;
        logic [15:0]        texture;
        logic [15:0]        tag;
        logic [6:0]         count;
    } t_reply;

    // Shadow copy of the list and the ordering register
    t_entry      list_entries [CAPACITY];
    int unsigned list_count;
    logic [1:0]  order_mode;
    t_reply      replies_due [$];
    int          fail_total;

    initial begin
        list_count            = 0;
        order_mode            = MODE_ASC_DEPTH;
        fail_total            = 0;
        o_fail_count          = 0;
        o_replies_outstanding = 0;
    end

    // True when the new item goes ahead of the held entry
    function automatic logic stays_ahead(t_entry held, t_entry fresh);
        case (order_mode)
            MODE_DESC_DEPTH: return $signed(held.depth) < $signed(fresh.depth);
            MODE_DESC_TEX:   return held.texture < fresh.texture;
            default:         return $signed(held.depth) > $signed(fresh.depth);
        endcase
    endfunction

    // Apply one operation to the shadow list and return its reply
    task automatic apply_list_op(input logic [1:0] op, input t_entry fresh,
                                 input logic [5:0] idx, output t_reply reply);
        int unsigned slot;
        int i;
        reply = '0;
        case (op)
            OP_INSERT: begin
                if (list_count >= CAPACITY) begin
                    reply.status = ST_FULL;
                end else begin
                    slot = list_count;
                    for (i = 0; i < list_count; i++) begin
                        if (stays_ahead(list_entries[i], fresh)) begin
                            slot = i;
                            break;
                        end
                    end
                    for (i = list_count; i > slot; i--) begin
                        list_entries[i] = list_entries[i-1];
                    end
                    list_entries[slot] = fresh;
                    list_count++;
                    reply.position = 7'(slot);
                end
            end
            OP_READ: begin
                if (idx >= list_count) begin
                    reply.status = ST_RANGE;
                end else begin
                    reply.depth   = list_entries[idx].depth;
                    reply.texture = list_entries[idx].texture;
                    reply.tag     = list_entries[idx].tag;
                end
            end
            OP_CLEAR: begin
                list_count = 0;
            end
            default: ;
        endcase
        reply.count = 7'(list_count);
    endtask

    task automatic check_field(input string label, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_reply made;
        t_entry fresh;
        if (!i_rst_n) begin
            list_count = 0;
            order_mode = MODE_ASC_DEPTH;
            replies_due.delete();
        end else begin
            // track register writes
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == SORT_MODE_ADDR) begin
                order_mode = i_pwdata[1:0];
            end

            // compare each result transfer against the oldest reply due
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result with no operation pending, status %0d count %0d",
                             $time, i_status, i_entry_count);
                    fail_total++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("position", want.position, i_position);
                    check_field("out_depth", want.depth, i_out_depth);
                    check_field("out_texture", want.texture, i_out_texture);
                    check_field("out_tag", want.tag, i_out_tag);
                    check_field("entry_count", want.count, i_entry_count);
                end
            end

            // predict the reply of each accepted operation
            if (i_in_valid && !i_in_stall) begin
                fresh.depth   = i_depth_key;
                fresh.texture = i_texture_key;
                fresh.tag     = i_item_tag;
                apply_list_op(i_opcode, fresh, i_read_index, made);
                replies_due.push_back(made);
            end
        end
        o_fail_count          <= fail_total;
        o_replies_outstanding <= replies_due.size();
    end

endmodule

// ===== tb/sv/tb_sorted_insertion_buffer.sv =====
`timescale 1ns / 1ps
module tb_sorted_insertion_buffer;
    import sib_pkg::*;

    localparam int         TARGET_ITEMS   = 1500;
    localparam int         QUIET_TAIL     = 150;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         IDLE_LIMIT     = 5000;
    localparam logic [2:0] SORT_MODE_ADDR = {REG_SORT_MODE, 2'b00};

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_psel         = 1'b0;
    logic               i_penable      = 1'b0;
    logic               i_pwrite       = 1'b0;
    logic [2:0]         i_paddr        = '0;
    logic [31:0]        i_pwdata       = '0;
    logic [31:0]        o_prdata;
    logic               o_pready;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode       = OP_INSERT;
    logic signed [31:0] i_depth_key    = '0;
    logic [15:0]        i_texture_key  = '0;
    logic [15:0]        i_item_tag     = '0;
    logic [5:0]         i_read_index   = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [1:0]         o_status;
    logic [6:0]         o_position;
    logic signed [31:0] o_out_depth;
    logic [15:0]        o_out_texture;
    logic [15:0]        o_out_tag;
    logic [6:0]         o_entry_count;

    int fail_count;
    int replies_outstanding;

    // stimulus controls and counters; stall_pct and hold_req are shared with the stall process
    int   gap_pct   = 0;
    int   stall_pct = 0;
    logic hold_req  = 1'b0;
    int   items_sent = 0;
    int   fill_level = 0;
    int   idle_cycles = 0;

    sorted_insertion_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .o_prdata      (o_prdata),
        .o_pready      (o_pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_depth_key   (i_depth_key),
        .i_texture_key (i_texture_key),
        .i_item_tag    (i_item_tag),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_out_depth   (o_out_depth),
        .o_out_texture (o_out_texture),
        .o_out_tag     (o_out_tag),
        .o_entry_count (o_entry_count)
    );

    sorted_list_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_psel                (i_psel),
        .i_penable             (i_penable),
        .i_pwrite              (i_pwrite),
        .i_paddr               (i_paddr),
        .i_pwdata              (i_pwdata),
        .i_pready              (o_pready),
        .i_in_valid            (i_in_valid),
        .i_in_stall            (o_in_stall),
        .i_opcode              (i_opcode),
        .i_depth_key           (i_depth_key),
        .i_texture_key         (i_texture_key),
        .i_item_tag            (i_item_tag),
        .i_read_index          (i_read_index),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .i_status              (o_status),
        .i_position            (o_position),
        .i_out_depth           (o_out_depth),
        .i_out_texture         (o_out_texture),
        .i_out_tag             (o_out_tag),
        .i_entry_count         (o_entry_count),
        .o_fail_count          (fail_count),
        .o_replies_outstanding (replies_outstanding)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver side: random stall bursts, plus one long hold on request
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            i_out_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            i_out_stall = 1'b0;
            hold_req    = 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            i_out_stall = 1'b1;
            repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Abort when nothing has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_sorted_insertion_buffer NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick_depth();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 8)) - 32'd4;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_texture();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // Offer one operation and wait for its transfer
    task automatic send_op(input logic [1:0] op, input logic [31:0] depth,
                           input logic [15:0] texture, input logic [15:0] tag,
                           input logic [5:0] idx);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_opcode      = op;
        i_depth_key   = depth;
        i_texture_key = texture;
        i_item_tag    = tag;
        i_read_index  = idx;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        case (op)
            OP_INSERT: if (fill_level < CAPACITY) fill_level++;
            OP_CLEAR:  fill_level = 0;
            default: ;
        endcase
    endtask

    task automatic send_insert(input logic [31:0] depth, input logic [15:0] texture,
                               input logic [15:0] tag);
        send_op(OP_INSERT, depth, texture, tag, 6'($urandom()));
    endtask

    task automatic send_read(input logic [5:0] idx);
        send_op(OP_READ, $urandom(), 16'($urandom()), 16'($urandom()), idx);
    endtask

    // Hold the sender until every result has come back
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        do @(posedge i_clk); while (replies_outstanding != 0);
    endtask

    task automatic write_sort_mode(input logic [1:0] mode);
        @(negedge i_clk);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = SORT_MODE_ADDR;
        i_pwdata  = {30'd0, mode};
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    initial begin
        int   phase;
        int   fill_goal;
        int   pick;
        logic [1:0] mode;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty read, unused opcode, field extremes, ties, range, clear
        send_read(6'd0);
        send_op(2'd3, 32'hffff_ffff, 16'hffff, 16'hffff, 6'h3f);
        send_insert(32'h0000_0000, 16'h0000, 16'h0000);
        send_insert(32'h7fff_ffff, 16'hffff, 16'hffff);
        send_insert(32'h8000_0000, 16'h0001, 16'h0001);
        send_insert(32'hffff_ffff, 16'h8000, 16'h0002);
        send_insert(32'h0000_0000, 16'h7fff, 16'h0003);
        for (int i = 0; i < 5; i++) send_read(6'(i));
        send_read(6'd5);
        send_read(6'h3f);
        send_op(OP_CLEAR, $urandom(), 16'($urandom()), 16'($urandom()), 6'($urandom()));
        send_read(6'd0);
        send_insert(32'h1234_5678, 16'haaaa, 16'h5555);
        send_read(6'd0);

        // Random phases, each with its own sort mode and idle pattern
        for (phase = 0; items_sent < TARGET_ITEMS; phase++) begin
            wait_for_drain();
            mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            write_sort_mode(mode);
            if (items_sent >= TARGET_ITEMS - QUIET_TAIL) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (phase == 2) begin
                // sender keeps offering while the receiver holds off
                gap_pct   = 0;
                stall_pct = 0;
                hold_req  = 1'b1;
            end else begin
                gap_pct   = pick_rate();
                stall_pct = pick_rate();
            end

            if (phase == 0 || $urandom_range(0, 4) != 0) begin
                // mostly a fresh list filled with reads mixed in
                if (phase < 4 || $urandom_range(0, 5) != 0) begin
                    send_op(OP_CLEAR, $urandom(), 16'($urandom()), 16'($urandom()),
                            6'($urandom()));
                end
                fill_goal = (phase == 0 || $urandom_range(0, 3) == 0) ?
                            $urandom_range(CAPACITY, CAPACITY + 8) : $urandom_range(1, 40);
                for (int n = 0; n < fill_goal; ) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 65 || (pick < 85 && fill_level == 0)) begin
                        send_insert(pick_depth(), pick_texture(), 16'($urandom()));
                        n++;
                    end else if (pick < 85) begin
                        send_read(6'($urandom_range(0, fill_level - 1)));
                    end else if (pick < 93) begin
                        send_read(6'($urandom()));
                    end else if (pick < 97) begin
                        send_op(2'd3, $urandom(), 16'($urandom()), 16'($urandom()),
                                6'($urandom()));
                    end else begin
                        send_read(6'(fill_level < CAPACITY ? fill_level : CAPACITY - 1));
                    end
                end
                // read back a few positions after the fill
                repeat ($urandom_range(0, 6)) begin
                    send_read(6'($urandom_range(0, CAPACITY - 1) % (fill_level + 1)));
                end
            end else begin
                // noise: any operation with any fields
                repeat ($urandom_range(5, 30)) begin
                    send_op(2'($urandom()), $urandom(), 16'($urandom()), 16'($urandom()),
                            6'($urandom()));
                end
            end
        end

        // Let the last results come back
        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && replies_outstanding == 0) begin
            $display("tb_sorted_insertion_buffer OK");
        end else begin
            $display("tb_sorted_insertion_buffer NOT OK");
        end
        $finish;
    end

endmodule
